FILE: rtl/core/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, character constants and entity pattern tables for the HTML
// entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

    localparam int JOB_MAX    = 6;
    localparam int JOB_CNT_W  = 3;
    localparam int HELD_DEPTH = 4;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        KIND_AMP  = 2'd0,
        KIND_GT   = 2'd1,
        KIND_LT   = 2'd2,
        KIND_QUOT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [JOB_MAX-1:0][7:0] bytes;
        logic [JOB_CNT_W-1:0]    count;
        logic                    last;
    } job_t;

    function automatic logic [7:0] fold_case(logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic [7:0] pat_char(kind_t k, logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            KIND_AMP:
            begin
                case (pos)
                    3'd0:    r = CH_A;
                    3'd1:    r = CH_M;
                    3'd2:    r = CH_P;
                    3'd3:    r = CH_SEMI;
                    default: r = 8'h00;
                endcase
            end
            KIND_GT:
            begin
                case (pos)
                    3'd0:    r = CH_G;
                    3'd1:    r = CH_T;
                    3'd2:    r = CH_SEMI;
                    default: r = 8'h00;
                endcase
            end
            KIND_LT:
            begin
                case (pos)
                    3'd0:    r = CH_L;
                    3'd1:    r = CH_T;
                    3'd2:    r = CH_SEMI;
                    default: r = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0:    r = CH_Q;
                    3'd1:    r = CH_U;
                    3'd2:    r = CH_O;
                    3'd3:    r = CH_T;
                    3'd4:    r = CH_SEMI;
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] pat_len(kind_t k);
        logic [2:0] r;
        case (k)
            KIND_AMP:  r = 3'd4;
            KIND_GT:   r = 3'd3;
            KIND_LT:   r = 3'd3;
            default:   r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] decoded_char(kind_t k);
        logic [7:0] r;
        case (k)
            KIND_AMP:  r = CH_AMP;
            KIND_GT:   r = CH_GT;
            KIND_LT:   r = CH_LT;
            default:   r = CH_QUOT;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/hed_if.sv
// ----------------------------------------------------------------------------
// hed_if
// Valid/ready stream interfaces for raw text bytes and decoded characters.
// ----------------------------------------------------------------------------
interface hed_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hed_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;

    modport source (output valid, output out_byte, output run_end, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_end, input string_end,
                    output ready);
endinterface

FILE: rtl/core/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front
// Matches entity names on the incoming text and turns each accepted byte
// that releases characters into one job holding every character it releases.
// ----------------------------------------------------------------------------
module hed_front
(
    input  logic          clk,
    input  logic          rst_n,
    hed_text_if.sink      text_ch,
    input  logic          job_ready,
    output logic          job_valid,
    output hed_pkg::job_t job
);
    import hed_pkg::*;

    logic                    in_entity_reg, in_entity_next;
    logic [2:0]              held_cnt_reg, held_cnt_next;
    kind_t                   kind_reg, kind_next;
    logic [HELD_DEPTH-1:0][7:0] held_reg, held_next;

    logic       accept;
    logic [7:0] c;
    logic [7:0] f;
    logic       first_hit;
    kind_t      first_kind;
    logic       flush_old;
    logic       flush_new;
    logic       mid_valid;
    logic [7:0] mid_byte;
    logic [JOB_CNT_W-1:0] pos;
    logic [JOB_MAX-1:0][7:0] bytes;

    assign c      = text_ch.in_byte;
    assign f      = fold_case(c);
    assign accept = text_ch.valid && text_ch.ready;
    assign text_ch.ready = job_ready;

    always_comb
    begin
        first_hit  = 1'b1;
        first_kind = KIND_AMP;
        case (f)
            CH_A:    first_kind = KIND_AMP;
            CH_G:    first_kind = KIND_GT;
            CH_L:    first_kind = KIND_LT;
            CH_Q:    first_kind = KIND_QUOT;
            default: first_hit  = 1'b0;
        endcase
    end

    always_comb
    begin
        in_entity_next = in_entity_reg;
        held_cnt_next  = held_cnt_reg;
        kind_next      = kind_reg;
        held_next      = held_reg;
        flush_old      = 1'b0;
        mid_valid      = 1'b0;
        mid_byte       = c;

        if (!in_entity_reg)
        begin
            if (c == CH_AMP)
            begin
                in_entity_next = 1'b1;
                held_cnt_next  = 3'd0;
                kind_next      = KIND_AMP;
            end
            else
            begin
                mid_valid = 1'b1;
            end
        end
        else if (held_cnt_reg == 3'd0 && first_hit)
        begin
            kind_next     = first_kind;
            held_next[0]  = c;
            held_cnt_next = 3'd1;
        end
        else if (held_cnt_reg != 3'd0 && pat_char(kind_reg, held_cnt_reg) == f)
        begin
            if (held_cnt_reg + 3'd1 == pat_len(kind_reg))
            begin
                mid_valid      = 1'b1;
                mid_byte       = decoded_char(kind_reg);
                in_entity_next = 1'b0;
                held_cnt_next  = 3'd0;
                kind_next      = KIND_AMP;
            end
            else
            begin
                held_next[held_cnt_reg[1:0]] = c;
                held_cnt_next = held_cnt_reg + 3'd1;
            end
        end
        else
        begin
            flush_old = 1'b1;
            kind_next = KIND_AMP;
            held_cnt_next = 3'd0;
            if (c == CH_AMP)
            begin
                in_entity_next = 1'b1;
            end
            else
            begin
                in_entity_next = 1'b0;
                mid_valid      = 1'b1;
            end
        end

        flush_new = text_ch.in_last && in_entity_next;

        pos   = '0;
        bytes = '0;
        if (flush_old)
        begin
            bytes[pos] = CH_AMP;
            pos = pos + 3'd1;
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                if (3'(i) < held_cnt_reg)
                begin
                    bytes[pos] = held_reg[i];
                    pos = pos + 3'd1;
                end
            end
        end
        if (mid_valid)
        begin
            bytes[pos] = mid_byte;
            pos = pos + 3'd1;
        end
        if (flush_new)
        begin
            bytes[pos] = CH_AMP;
            pos = pos + 3'd1;
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                if (3'(i) < held_cnt_next)
                begin
                    bytes[pos] = held_next[i];
                    pos = pos + 3'd1;
                end
            end
            in_entity_next = 1'b0;
            held_cnt_next  = 3'd0;
            kind_next      = KIND_AMP;
        end
    end

    assign job.bytes = bytes;
    assign job.count = pos;
    assign job.last  = text_ch.in_last;
    assign job_valid = accept && (pos != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_entity_reg <= 1'b0;
            held_cnt_reg  <= 3'd0;
            kind_reg      <= KIND_AMP;
        end
        else if (accept)
        begin
            in_entity_reg <= in_entity_next;
            held_cnt_reg  <= held_cnt_next;
            kind_reg      <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

`ifndef SYNTHESIS
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text_ch.in_last) |-> job_valid)
        else $error("last byte produced no transaction");
`endif

endmodule

FILE: rtl/core/hed_queue.sv
// ----------------------------------------------------------------------------
// hed_queue
// Four-entry job queue between the matching front end and the serializer.
// ----------------------------------------------------------------------------
module hed_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hed_pkg::job_t push_job,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output hed_pkg::job_t pop_job
);
    import hed_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[QPTR_W-1:0] == (wr_ptr_reg - rd_ptr_reg)) &&
        (count_reg <= QCNT_W'(QDEPTH)))
        else $error("queue pointers and count disagree");
`endif

endmodule

FILE: rtl/core/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back
// Takes jobs from the queue and sends their characters out one per cycle,
// while the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module hed_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  hed_pkg::job_t job,
    output logic          job_pop,
    hed_char_if.source    dec_ch
);
    import hed_pkg::*;

    logic                 cur_valid_reg, cur_valid_next;
    job_t                 cur_job_reg;
    logic [JOB_CNT_W-1:0] cur_idx_reg, cur_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 run_end_reg;
    logic                 string_end_reg;
    logic                 load;
    logic                 cur_final;

    assign load      = cur_valid_reg && (!out_valid_reg || dec_ch.ready);
    assign cur_final = cur_idx_reg == (cur_job_reg.count - 3'd1);
    assign job_pop   = job_valid && (!cur_valid_reg || (load && cur_final));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_idx_next   = cur_idx_reg;
        if (job_pop)
        begin
            cur_valid_next = 1'b1;
            cur_idx_next   = '0;
        end
        else if (load)
        begin
            if (cur_final)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                cur_idx_next = cur_idx_reg + 3'd1;
            end
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (dec_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_idx_reg   <= cur_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_job_reg <= job;
        end
        if (load)
        begin
            out_byte_reg   <= cur_job_reg.bytes[cur_idx_reg];
            run_end_reg    <= cur_final;
            string_end_reg <= cur_final && cur_job_reg.last;
        end
    end

    assign dec_ch.valid      = out_valid_reg;
    assign dec_ch.out_byte   = out_byte_reg;
    assign dec_ch.run_end    = run_end_reg;
    assign dec_ch.string_end = string_end_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_idx_reg < cur_job_reg.count))
        else $error("character index beyond job length");

    a_string_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!string_end_reg || run_end_reg))
        else $error("string end without run end");

    a_pop_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (job_pop && cur_valid_reg) |-> (load && cur_final))
        else $error("job replaced before all characters were sent");
`endif

endmodule

FILE: rtl/core/html_entity_decoder_core.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_core
// Streaming decoder for the &amp; &gt; &lt; and &quot; character entities.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while the queue has room and
// matches entity names without regard to case; a byte that releases several
// characters (an ampersand and held letters after a mismatch, up to six) is
// queued as one job, and the output side sends one character per cycle while
// the output is ready, so each transaction on the output carries one
// character. Input is accepted every cycle while the four-job queue has room;
// it stalls only when the output side falls behind. With the output side
// idle, the first character of a job passes through the queue entry, the
// current-job register and the output register before it reaches the output.
// ----------------------------------------------------------------------------
module html_entity_decoder_core
(
    input  logic       clk,
    input  logic       rst_n,
    hed_text_if.sink   text_ch,
    hed_char_if.source dec_ch
);
    import hed_pkg::*;

    logic push;
    logic push_ready;
    job_t push_job;
    logic pop;
    logic pop_valid;
    job_t pop_job;

    hed_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_ch   (text_ch),
        .job_ready (push_ready),
        .job_valid (push),
        .job       (push_job)
    );

    hed_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job)
    );

    hed_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .dec_ch    (dec_ch)
    );

endmodule

FILE: bench/hed_checker.sv
// ----------------------------------------------------------------------------
// hed_checker
// Watches both channels of the HTML entity decoder. Every accepted text
// transaction runs through a decoding predictor whose released characters are
// queued; every accepted character transaction is compared against the oldest
// queued character, including its run_end and string_end flags.
// ----------------------------------------------------------------------------
module hed_checker
(
    input  logic  clk,
    input  logic  rst_n,
    hed_text_if   text_mon,
    hed_char_if   char_mon,
    output int    error_count,
    output int    pending_count,
    output int    checked_count,
    output int    ends_count
);
    import hed_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       string_end;
    } dec_char_t;

    string      ent_names [4] = '{"amp;", "gt;", "lt;", "quot;"};
    logic [7:0] ent_value [4] = '{CH_AMP, CH_GT, CH_LT, CH_QUOT};

    logic        ent_open;
    logic [2:0]  held_n;
    logic [7:0]  held_buf [HELD_DEPTH];
    kind_t       ent_kind;

    logic [7:0]  release_buf [$];
    dec_char_t   expected_chars [$];

    int n_errors;
    int n_checked;
    int n_ends;

    assign error_count   = n_errors;
    assign pending_count = expected_chars.size();
    assign checked_count = n_checked;
    assign ends_count    = n_ends;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            return c + CASE_OFS;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        n_errors++;
    endtask

    task automatic release_entity();
        int i;
        release_buf.push_back(CH_AMP);
        for (i = 0; i < held_n; i++)
        begin
            release_buf.push_back(held_buf[i]);
        end
        ent_open = 1'b0;
        held_n   = 3'd0;
        ent_kind = KIND_AMP;
    endtask

    task automatic take_plain(input logic [7:0] c);
        if (c == CH_AMP)
        begin
            ent_open = 1'b1;
            held_n   = 3'd0;
            ent_kind = KIND_AMP;
        end
        else
        begin
            release_buf.push_back(c);
        end
    endtask

    task automatic decode_predict(input logic [7:0] c, input logic last);
        logic [7:0] f;
        int         pos;
        int         k;
        int         i;
        int         name_len;
        bit         matched;
        dec_char_t  item;
        f = lower_ascii(c);
        release_buf.delete();
        if (!ent_open)
        begin
            take_plain(c);
        end
        else if (held_n == 3'd0)
        begin
            matched = 1'b0;
            for (k = 0; k < 4; k++)
            begin
                if (!matched && ent_names[k][0] == f)
                begin
                    ent_kind    = kind_t'(k);
                    held_buf[0] = c;
                    held_n      = 3'd1;
                    matched     = 1'b1;
                end
            end
            if (!matched)
            begin
                release_entity();
                take_plain(c);
            end
        end
        else
        begin
            pos      = held_n;
            name_len = ent_names[ent_kind].len();
            if (pos < name_len && ent_names[ent_kind][pos] == f)
            begin
                if (pos + 1 == name_len)
                begin
                    release_buf.push_back(ent_value[ent_kind]);
                    ent_open = 1'b0;
                    held_n   = 3'd0;
                    ent_kind = KIND_AMP;
                end
                else if (pos < HELD_DEPTH)
                begin
                    held_buf[pos] = c;
                    held_n        = 3'(pos + 1);
                end
            end
            else
            begin
                release_entity();
                take_plain(c);
            end
        end
        if (last && ent_open)
        begin
            release_entity();
        end
        for (i = 0; i < release_buf.size(); i++)
        begin
            item.ch         = release_buf[i];
            item.run_end    = (i == release_buf.size() - 1);
            item.string_end = last && (i == release_buf.size() - 1);
            expected_chars.push_back(item);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dec_char_t want;
        dec_char_t got;
        if (!rst_n)
        begin
            ent_open = 1'b0;
            held_n   = 3'd0;
            ent_kind = KIND_AMP;
            expected_chars.delete();
        end
        else
        begin
            if (text_mon.valid && text_mon.ready)
            begin
                decode_predict(text_mon.in_byte, text_mon.in_last);
            end
            if (char_mon.valid && char_mon.ready)
            begin
                got = {char_mon.out_byte, char_mon.run_end, char_mon.string_end};
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 8'h%02h run_end %b string_end %b",
                                              got.ch, got.run_end, got.string_end));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (got !== want)
                    begin
                        report_mismatch($sformatf(
                            "character %0d: got 8'h%02h/%b/%b, expected 8'h%02h/%b/%b",
                            n_checked, got.ch, got.run_end, got.string_end,
                            want.ch, want.run_end, want.string_end));
                    end
                    n_checked++;
                    if (want.string_end)
                    begin
                        n_ends++;
                    end
                end
            end
        end
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for html_entity_decoder_core. A short directed text covers
// entities in mixed case, the longest mismatch, ampersands inside a partial
// match, zero and all-ones bytes and string ends with a partial entity held.
// A random text of entities, cut-off entities, stray letters and arbitrary
// bytes follows, with random idle bursts on both channels. The checker module
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import hed_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int CALM_ITEMS   = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;

    logic clk;
    logic rst_n;

    hed_text_if text_ch ();
    hed_char_if dec_ch ();

    logic [7:0] stim_bytes [$];
    bit         stim_last [$];
    bit         calm = 1'b0;
    int         n_sent = 0;
    int         n_directed;
    int         cycle_count = 0;
    int         n_errors;
    int         n_pending;
    int         n_checked;
    int         n_ends;

    string ent_names [4] = '{"amp;", "gt;", "lt;", "quot;"};
    string stray_chars   = "amplgtquoAMPLGTQUO;&";

    html_entity_decoder_core u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_ch (text_ch),
        .dec_ch  (dec_ch)
    );

    hed_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_mon      (text_ch),
        .char_mon      (dec_ch),
        .error_count   (n_errors),
        .pending_count (n_pending),
        .checked_count (n_checked),
        .ends_count    (n_ends)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_char(input logic [7:0] c, input bit last);
        stim_bytes.push_back(c);
        stim_last.push_back(last);
    endtask

    task automatic add_str(input string s, input bit last_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            add_char(s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] random_case(input logic [7:0] c);
        if (c >= CH_A && c <= 8'h7A && $urandom_range(0, 1) == 1)
        begin
            return c - CASE_OFS;
        end
        return c;
    endfunction

    initial
    begin
        int    i;
        int    k;
        int    cut;
        int    mode;
        string name;
        rst_n           <= 1'b0;
        text_ch.valid   <= 1'b0;
        text_ch.in_byte <= 8'h00;
        text_ch.in_last <= 1'b0;

        add_str("&AmP;", 1'b0);
        add_str("&Lt;", 1'b0);
        add_str("&QUOtZ", 1'b0);
        add_str("&l&gt;", 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b1);
        add_str("&x", 1'b0);
        add_str("&qu", 1'b1);
        n_directed = stim_bytes.size();

        while (stim_bytes.size() < n_directed + RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
            begin
                k    = $urandom_range(0, 3);
                name = ent_names[k];
                cut  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, name.len() - 1)
                                                   : name.len();
                add_char(CH_AMP, $urandom_range(0, 15) == 0);
                for (i = 0; i < cut; i++)
                begin
                    add_char(random_case(name[i]), $urandom_range(0, 15) == 0);
                end
            end
            else if (mode < 8)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    add_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                end
            end
            else if (mode == 8)
            begin
                add_char(CH_AMP, $urandom_range(0, 9) == 0);
            end
            else
            begin
                add_char(stray_chars[$urandom_range(0, stray_chars.len() - 1)],
                         $urandom_range(0, 9) == 0);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < stim_bytes.size(); i++)
        begin
            if (i >= stim_bytes.size() - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            if (!calm && ((i / 50) % 4 != 3) && $urandom_range(0, 3) == 0)
            begin
                text_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            text_ch.valid   <= 1'b1;
            text_ch.in_byte <= stim_bytes[i];
            text_ch.in_last <= stim_last[i];
            do
                @(posedge clk);
            while (text_ch.ready !== 1'b1);
            n_sent++;
        end
        text_ch.valid <= 1'b0;
        @(posedge clk);

        while (n_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d text transactions (%0d directed, the rest random).",
                 n_sent, n_directed);
        $display("Checked %0d decoded characters across %0d completed strings.",
                 n_checked, n_ends);
        if (n_errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        dec_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                dec_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            dec_ch.ready <= 1'b1;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 6)) @(posedge clk);
        end
    end

endmodule
